// File: sv/hkm_pkg.sv
// hkm_pkg: shared constants, codes and types of the hashed key map
// no dependencies; imported by every module and interface of the block
package hkm_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int VALUE_W = 32;
	localparam int HASH_W = 64;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [HASH_W-1:0] HASH_SEED = 64'd17;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_GET = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	localparam logic [1:0] STAT_DONE = 2'd0;
	localparam logic [1:0] STAT_FOUND = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [1:0] STAT_FULL = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [VALUE_W-1:0] value;
		logic [HASH_W-1:0] hash;
	} hkm_cmd_t;

	typedef struct packed {
		logic [HASH_W-1:0] hash;
		logic occupied;
		logic [VALUE_W-1:0] value;
	} hkm_slot_t;

endpackage

// File: sv/hkm_intf.sv
// hkm_in_if / hkm_out_if: valid-ready channels for key words and result words
// depends on hkm_pkg for field widths
interface hkm_in_if
	import hkm_pkg::*;
;
	logic valid;
	logic ready;
	logic [1:0] op;
	logic [7:0] key_byte;
	logic key_last;
	logic [VALUE_W-1:0] new_value;

	modport source (output valid, op, key_byte, key_last, new_value, input ready);
	modport sink (input valid, op, key_byte, key_last, new_value, output ready);
endinterface

interface hkm_out_if
	import hkm_pkg::*;
;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [VALUE_W-1:0] read_value;
	logic [HASH_W-1:0] key_hash;

	modport source (output valid, status, read_value, key_hash, input ready);
	modport sink (input valid, status, read_value, key_hash, output ready);
endinterface

// File: sv/hashed_key_map_linear_probe.sv
// hashed_key_map_linear_probe: top level of the hashed key map
// depends on hkm_pkg, hkm_intf, hkm_front, hkm_queue, hkm_back
//
// key_in carries one key byte per word with op, key_last and new_value; a
// word is taken when valid and ready are both high. Bytes are hashed one per
// cycle while ready is high. The word marked key_last completes the hash and
// queues one table operation (insert, get or remove); other words give no result.
// res_out carries one result word per key: status, read_value and key_hash.
// The probing side walks the 256-slot table one slot at a time, each slot
// passing a memory read state (S_LOAD) and a compare state (S_PROBE); an
// operation inspects p slots once dequeued, p from 1 to 256.
// A two-entry queue lets bytes of following keys be hashed while a walk runs;
// key_in.ready drops only when the queue is full.
// If res_out is stalled, the finished result waits in the output register
// and the walk of the next key holds at its final slot until the register frees.
// Reset reloads the hash seed, empties the queue and clears a per-slot valid
// bit, so every slot reads as unused at once; no clearing pass is needed.
module hashed_key_map_linear_probe
	import hkm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	hkm_in_if.sink key_in,
	hkm_out_if.source res_out
);

	logic push_valid;
	logic push_ready;
	hkm_cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	hkm_cmd_t pop_cmd;

	hkm_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.key_in(key_in),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd(push_cmd)
	);

	hkm_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd(push_cmd),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_cmd(pop_cmd)
	);

	hkm_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_cmd(pop_cmd),
		.res_out(res_out)
	);

`ifndef ASSERT_OFF
	a_last_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(key_in.valid && key_in.ready && key_in.key_last) |-> (push_valid && push_ready))
		else $error("accepted last byte not queued");

	a_queue_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && push_ready && !pop_valid) |=> pop_valid)
		else $error("queued command not visible to probe side");

	a_one_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && pop_ready) |=> !pop_ready)
		else $error("probe side took a command while walking");
`endif

endmodule

// File: sv/hkm_front.sv
// hkm_front: per-byte hash accumulation, emits one command per finished key
// depends on hkm_pkg and hkm_in_if
module hkm_front
	import hkm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	hkm_in_if.sink key_in,
	output logic push_valid,
	input  logic push_ready,
	output hkm_cmd_t push_cmd
);

	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] sext_byte;
	logic signed [8:0] mult;
	logic signed [HASH_W+9:0] prod;
	logic [HASH_W-1:0] prod_lo;
	logic [HASH_W-1:0] hash_next;
	logic take;

	// 2*s+1 of a signed byte is the byte with a one appended
	assign mult = $signed({key_in.key_byte, 1'b1});
	assign sext_byte = {{(HASH_W-8){key_in.key_byte[7]}}, key_in.key_byte};
	assign prod = $signed({1'b0, hash_q}) * mult;
	assign prod_lo = prod[HASH_W-1:0];
	assign hash_next = {prod_lo[HASH_W-8:0], prod_lo[HASH_W-1:HASH_W-7]} ^ sext_byte;

	assign key_in.ready = push_ready;
	assign take = key_in.valid && push_ready;

	assign push_valid = key_in.valid && key_in.key_last;
	assign push_cmd.op = key_in.op;
	assign push_cmd.value = key_in.new_value;
	assign push_cmd.hash = hash_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HASH_SEED;
		end else if (take) begin
			hash_q <= key_in.key_last ? HASH_SEED : hash_next;
		end
	end

endmodule

// File: sv/hkm_queue.sv
// hkm_queue: short command queue between hashing front and probing back
// depends on hkm_pkg
module hkm_queue
	import hkm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  hkm_cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output hkm_cmd_t pop_cmd
);

	hkm_cmd_t entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_cmd = entry_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

// File: sv/hkm_back.sv
// hkm_back: linear-probe walk over the slot table and result word register
// depends on hkm_pkg and hkm_out_if
module hkm_back
	import hkm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic pop_valid,
	output logic pop_ready,
	input  hkm_cmd_t pop_cmd,
	hkm_out_if.source res_out
);

	typedef enum logic [1:0] {S_IDLE, S_LOAD, S_PROBE} state_t;

	state_t state_q;
	hkm_cmd_t cmd_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] cnt_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	hkm_slot_t mem [TABLE_DEPTH];
	hkm_slot_t rdata_q;
	logic rvld_q;

	logic out_valid_q;
	logic [1:0] status_q;
	logic [VALUE_W-1:0] value_q;
	logic [HASH_W-1:0] hash_q;

	hkm_slot_t slot;
	hkm_slot_t wr_data;
	logic hit;
	logic zero;
	logic stop;
	logic wr_req;
	logic wr_en;
	logic out_free;
	logic finish;
	logic [1:0] res_status;
	logic [VALUE_W-1:0] res_value;

	assign slot = rvld_q ? rdata_q : '0;
	assign hit = (slot.hash == cmd_q.hash);
	assign zero = (slot.hash == '0);
	assign out_free = !out_valid_q || res_out.ready;

	always_comb begin
		stop = 1'b0;
		wr_req = 1'b0;
		wr_data = slot;
		res_status = STAT_NOT_FOUND;
		res_value = '0;
		unique case (cmd_q.op)
			OP_INSERT: begin
				if (hit || !slot.occupied) begin
					stop = 1'b1;
					wr_req = 1'b1;
					wr_data.hash = cmd_q.hash;
					wr_data.occupied = 1'b1;
					wr_data.value = cmd_q.value;
					res_status = STAT_DONE;
				end
			end
			OP_GET, OP_REMOVE: begin
				if (zero) begin
					stop = 1'b1;
				end else if (hit) begin
					stop = 1'b1;
					if (cmd_q.op == OP_GET) begin
						if (slot.occupied) begin
							res_status = STAT_FOUND;
							res_value = slot.value;
						end
					end else begin
						// tombstone keeps the hash
						wr_req = 1'b1;
						wr_data.occupied = 1'b0;
						wr_data.value = '0;
						res_status = slot.occupied ? STAT_DONE : STAT_NOT_FOUND;
					end
				end
			end
			default: begin
				stop = 1'b1;
			end
		endcase
		if (!stop && (cnt_q == '1)) begin
			stop = 1'b1;
			res_status = STAT_FULL;
		end
	end

	assign finish = (state_q == S_PROBE) && stop && out_free;
	assign wr_en = finish && wr_req;
	assign pop_ready = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx_q] <= wr_data;
		end
		rdata_q <= mem[idx_q];
		if (pop_valid && pop_ready) begin
			cmd_q <= pop_cmd;
		end
		if (finish) begin
			status_q <= res_status;
			value_q <= res_value;
			hash_q <= cmd_q.hash;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			cnt_q <= '0;
			valid_q <= '0;
			rvld_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rvld_q <= valid_q[idx_q];
			if (wr_en) begin
				valid_q[idx_q] <= 1'b1;
			end
			if (res_out.ready) begin
				out_valid_q <= 1'b0;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop_valid) begin
						idx_q <= pop_cmd.hash[IDX_W-1:0];
						cnt_q <= '0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					state_q <= S_PROBE;
				end
				S_PROBE: begin
					if (finish) begin
						state_q <= S_IDLE;
					end else if (!stop) begin
						idx_q <= idx_q + IDX_W'(1);
						cnt_q <= cnt_q + IDX_W'(1);
						state_q <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_out.valid = out_valid_q;
	assign res_out.status = status_q;
	assign res_out.read_value = value_q;
	assign res_out.key_hash = hash_q;

endmodule

// File: bench/tb.sv
// tb: self-checking bench for hashed_key_map_linear_probe, driving key words and checking results
// depends on hkm_pkg, hkm_in_if / hkm_out_if and the block's rtl
`timescale 1ns / 100ps

module tb;
	import hkm_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int POOL_KEYS = 24;
	localparam int FILL_KEYS = 300;
	localparam int QUIET_WORDS = 160;
	localparam int LONG_HOLD_AFTER = 30;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 600;

	typedef struct packed {
		logic hold;
		logic [1:0] op;
		logic [7:0] key_byte;
		logic key_last;
		logic [VALUE_W-1:0] new_value;
	} key_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic [VALUE_W-1:0] read_value;
		logic [HASH_W-1:0] key_hash;
	} map_result_t;

	typedef struct packed {
		logic [2:0] len;
		logic [31:0] bytes;
	} key_t;

	logic clk;
	logic arst_n;

	hkm_in_if key_if ();
	hkm_out_if res_if ();

	hashed_key_map_linear_probe DUT (
		.clk(clk),
		.arst_n(arst_n),
		.key_in(key_if.sink),
		.res_out(res_if.source)
	);

	key_word_t key_words[$];
	map_result_t due_results[$];
	key_t pool[POOL_KEYS];
	key_word_t cur_word;
	int errors = 0;
	int results_seen;
	int src_gap;
	int sink_gap;
	int long_hold;
	bit hold_done;
	bit quiet;

	logic [HASH_W-1:0] run_hash;
	logic [HASH_W-1:0] map_hash[TABLE_DEPTH];
	bit map_used[TABLE_DEPTH];
	logic [VALUE_W-1:0] map_val[TABLE_DEPTH];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	function automatic logic [HASH_W-1:0] fold_byte(input logic [HASH_W-1:0] h,
			input logic [7:0] b);
		logic [HASH_W-1:0] s;
		logic [HASH_W-1:0] p;
		s = {{(HASH_W-8){b[7]}}, b};
		p = h * ((s << 1) + 64'd1);
		p = {p[HASH_W-8:0], p[HASH_W-1:HASH_W-7]};
		return p ^ s;
	endfunction

	// hash the byte; on the last byte walk the table and queue the result word
	task automatic absorb_key_word(input key_word_t w);
		map_result_t r;
		logic [HASH_W-1:0] h;
		logic [IDX_W-1:0] idx;
		bit stop;
		run_hash = fold_byte(run_hash, w.key_byte);
		if (w.key_last) begin
			h = run_hash;
			run_hash = HASH_SEED;
			r.status = STAT_FULL;
			r.read_value = '0;
			r.key_hash = h;
			idx = h[IDX_W-1:0];
			stop = 1'b0;
			if (w.op == OP_UNUSED) begin
				r.status = STAT_NOT_FOUND;
			end else begin
				for (int n = 0; n < TABLE_DEPTH && !stop; n++) begin
					if (w.op == OP_INSERT) begin
						if (map_hash[idx] == h || !map_used[idx]) begin
							map_hash[idx] = h;
							map_used[idx] = 1'b1;
							map_val[idx] = w.new_value;
							r.status = STAT_DONE;
							stop = 1'b1;
						end
					end else if (map_hash[idx] == '0) begin
						r.status = STAT_NOT_FOUND;
						stop = 1'b1;
					end else if (map_hash[idx] == h) begin
						if (w.op == OP_GET) begin
							if (map_used[idx]) begin
								r.status = STAT_FOUND;
								r.read_value = map_val[idx];
							end else begin
								r.status = STAT_NOT_FOUND;
							end
						end else begin
							r.status = map_used[idx] ? STAT_DONE : STAT_NOT_FOUND;
							map_used[idx] = 1'b0;
							map_val[idx] = '0;
						end
						stop = 1'b1;
					end
					if (!stop)
						idx = idx + 1'b1;
				end
			end
			due_results.push_back(r);
		end
	endtask

	task automatic add_key(input key_t k, input logic [1:0] op, input logic [VALUE_W-1:0] val,
			input bit hold);
		key_word_t w;
		for (int i = 0; i < k.len; i++) begin
			w.hold = hold && (i == 0);
			w.key_byte = k.bytes[8*i +: 8];
			w.key_last = (i == k.len - 1);
			w.op = w.key_last ? op : 2'($urandom);
			w.new_value = w.key_last ? val : $urandom;
			key_words.push_back(w);
		end
	endtask

	function automatic key_t rand_key();
		key_t k;
		k.len = 3'($urandom_range(1, 4));
		k.bytes = $urandom;
		return k;
	endfunction

	function automatic logic [1:0] pick_op();
		int r;
		r = $urandom_range(0, 19);
		if (r < 8)
			return OP_INSERT;
		else if (r < 15)
			return OP_GET;
		else if (r < 19)
			return OP_REMOVE;
		return OP_UNUSED;
	endfunction

	function automatic key_t fill_key(input int k);
		key_t f;
		f.len = 3'd2;
		f.bytes = {16'd0, 8'(k >> 8) ^ 8'hC3, 8'(k)};
		return f;
	endfunction

	task automatic pool_mix(input int words, input bit hold);
		int target;
		key_t k;
		target = key_words.size() + words;
		while (key_words.size() < target) begin
			if ($urandom_range(0, 9) == 0)
				k = rand_key();
			else
				k = pool[$urandom_range(0, POOL_KEYS - 1)];
			add_key(k, pick_op(), $urandom, hold);
			hold = 1'b0;
		end
	endtask

	// fill every slot with distinct keys, then work the full and tombstoned table
	task automatic fill_phase();
		key_t k;
		int r;
		for (int i = 0; i < FILL_KEYS; i++)
			add_key(fill_key(i), OP_INSERT, $urandom, i == 0);
		for (int i = 0; i < 60; i++) begin
			r = $urandom_range(0, 5);
			k = rand_key();
			k.len = 3'd3;
			case (r)
				0: add_key(fill_key($urandom_range(0, FILL_KEYS - 1)), OP_GET, $urandom, 1'b0);
				1: add_key(k, OP_INSERT, $urandom, 1'b0);
				2: add_key(k, OP_GET, $urandom, 1'b0);
				3: add_key(k, OP_REMOVE, $urandom, 1'b0);
				4: add_key(fill_key($urandom_range(0, FILL_KEYS - 1)), OP_INSERT, $urandom,
					1'b0);
				default: add_key(fill_key($urandom_range(0, FILL_KEYS - 1)), OP_REMOVE,
					$urandom, 1'b0);
			endcase
		end
	endtask

	// word source
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_if.valid <= 1'b0;
			key_if.op <= '0;
			key_if.key_byte <= '0;
			key_if.key_last <= 1'b0;
			key_if.new_value <= '0;
			src_gap <= 0;
			quiet <= 1'b0;
		end else begin
			if (key_if.valid && key_if.ready)
				absorb_key_word(cur_word);
			if (!key_if.valid || key_if.ready) begin
				if (src_gap != 0) begin
					src_gap <= src_gap - 1;
					key_if.valid <= 1'b0;
				end else if (key_words.size() == 0
						|| (key_words[0].hold && due_results.size() != 0)) begin
					key_if.valid <= 1'b0;
				end else begin
					cur_word = key_words.pop_front();
					key_if.op <= cur_word.op;
					key_if.key_byte <= cur_word.key_byte;
					key_if.key_last <= cur_word.key_last;
					key_if.new_value <= cur_word.new_value;
					key_if.valid <= 1'b1;
					if (!quiet && $urandom_range(0, 5) == 0)
						src_gap <= $urandom_range(1, 5);
				end
			end
			if (key_words.size() < QUIET_WORDS)
				quiet <= 1'b1;
		end
	end

	// result sink and checker
	always @(posedge clk or negedge arst_n) begin
		map_result_t exp_r;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			sink_gap <= 0;
			results_seen <= 0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				results_seen <= results_seen + 1;
				if (due_results.size() == 0) begin
					flag_mismatch($sformatf("unexpected result word, hash %h", res_if.key_hash));
				end else begin
					exp_r = due_results.pop_front();
					if (res_if.status !== exp_r.status)
						flag_mismatch($sformatf("status %0d, want %0d (hash %h)",
							res_if.status, exp_r.status, exp_r.key_hash));
					if (res_if.read_value !== exp_r.read_value)
						flag_mismatch($sformatf("read_value %h, want %h (hash %h)",
							res_if.read_value, exp_r.read_value, exp_r.key_hash));
					if (res_if.key_hash !== exp_r.key_hash)
						flag_mismatch($sformatf("key_hash %h, want %h",
							res_if.key_hash, exp_r.key_hash));
				end
			end
			if (long_hold != 0) begin
				res_if.ready <= 1'b0;
			end else if (sink_gap != 0) begin
				sink_gap <= sink_gap - 1;
				res_if.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 6) == 0) begin
				sink_gap <= $urandom_range(0, 4);
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// one long back-pressure stretch so the input side fills and stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_hold <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && results_seen >= LONG_HOLD_AFTER) begin
			long_hold <= LONG_HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (long_hold != 0) begin
			long_hold <= long_hold - 1;
		end
	end

	initial begin
		#50_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		key_if.valid = 1'b0;
		key_if.op = '0;
		key_if.key_byte = '0;
		key_if.key_last = 1'b0;
		key_if.new_value = '0;
		res_if.ready = 1'b0;
		run_hash = HASH_SEED;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			map_hash[i] = '0;
			map_used[i] = 1'b0;
			map_val[i] = '0;
		end

		add_key(key_t'{3'd1, 32'h0000_0000}, OP_INSERT, 32'hFFFF_FFFF, 1'b0);
		add_key(key_t'{3'd1, 32'h0000_00FF}, OP_INSERT, 32'h0000_0000, 1'b0);
		add_key(key_t'{3'd1, 32'h0000_0000}, OP_GET, $urandom, 1'b0);
		add_key(key_t'{3'd1, 32'h0000_007F}, OP_GET, $urandom, 1'b0);
		add_key(key_t'{3'd2, 32'h0000_7F80}, OP_INSERT, 32'h1234_5678, 1'b0);
		add_key(key_t'{3'd2, 32'h0000_7F80}, OP_GET, $urandom, 1'b0);
		add_key(key_t'{3'd1, 32'h0000_0000}, OP_INSERT, 32'h0000_0000, 1'b0);
		add_key(key_t'{3'd1, 32'h0000_0000}, OP_GET, $urandom, 1'b0);
		add_key(key_t'{3'd1, 32'h0000_00FF}, OP_REMOVE, $urandom, 1'b0);
		add_key(key_t'{3'd1, 32'h0000_00FF}, OP_GET, $urandom, 1'b0);
		add_key(key_t'{3'd1, 32'h0000_00FF}, OP_REMOVE, $urandom, 1'b0);
		add_key(key_t'{3'd1, 32'h0000_0055}, OP_UNUSED, $urandom, 1'b0);
		add_key(key_t'{3'd1, 32'h0000_007F}, OP_REMOVE, $urandom, 1'b0);
		add_key(key_t'{3'd1, 32'h0000_00FF}, OP_INSERT, 32'hA5A5_A5A5, 1'b0);
		add_key(key_t'{3'd1, 32'h0000_00FF}, OP_GET, $urandom, 1'b0);
		add_key(key_t'{3'd4, 32'h80FF_007F}, OP_INSERT, $urandom, 1'b0);

		for (int i = 0; i < POOL_KEYS; i++)
			pool[i] = rand_key();
		pool_mix(800, 1'b0);
		fill_phase();
		pool_mix(170, 1'b1);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (key_words.size() != 0 || key_if.valid)
			@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
